// ----- design/keyed_record_table_defines.svh -----
// assertion macros for the keyed record table
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define KRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("krt check failed");
// consequent must hold in the cycle after the antecedent
`define KRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("krt check failed");
`else
`define KRT_ASSERT(lbl, prop)
`define KRT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/krt_pkg.sv -----
`default_nettype none

package krt_pkg;

  localparam int DEF_ENTRIES = 64;
  localparam int KEY_W       = 32;
  localparam int PAY_W       = 32;
  localparam int COUNT_W     = 7;
  localparam int REQ_W       = 3;
  localparam int STAT_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_SEARCH = 3'd1,
    REQ_UPDATE = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_DUMP   = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_EMIT
  } state_e;

  // one stored record, as kept in the record memory
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } rec_t;

endpackage

`default_nettype wire

// ----- design/keyed_record_table.sv -----
// channel | handshake              | beat contents
// in      | in_valid_i / in_stall_o   | req_type_i, key_i, payload_i
// out     | out_valid_o / out_stall_i | status_o, found_key_o, found_payload_o,
//         |                           | entry_count_o, last_o
//
// timing: add writes at the fill count directly; search, update, delete and dump walk the
//   stored records, all through the single read port of the record memory
// reset: rst_ni async, clears fill count, sequencer and output valid; no clearing pass
// in_stall_o is high while a request is being worked on
// a finished result waits in the output register while the next request is taken
`default_nettype none

module keyed_record_table #(
  parameter int ENTRIES = krt_pkg::DEF_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request beats
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [krt_pkg::REQ_W-1:0]        req_type_i,
  input  logic signed [krt_pkg::KEY_W-1:0] key_i,
  input  logic [krt_pkg::PAY_W-1:0]        payload_i,
  // result beats
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [krt_pkg::STAT_W-1:0]       status_o,
  output logic signed [krt_pkg::KEY_W-1:0] found_key_o,
  output logic [krt_pkg::PAY_W-1:0]        found_payload_o,
  output logic [krt_pkg::COUNT_W-1:0]      entry_count_o,
  output logic                             last_o
);

  // record address width, at least one bit for a single-entry table
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // record memory port between sequencer and storage
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  krt_pkg::rec_t rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  krt_pkg::rec_t wr_data;

  // sequencer: decodes requests, scans and compacts the table, drives results
  krt_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_key_o     (found_key_o),
    .found_payload_o (found_payload_o),
    .entry_count_o   (entry_count_o),
    .last_o          (last_o),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

  // key and payload pairs, dense from address zero up to the fill count
  krt_mem #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule

`default_nettype wire

// ----- design/krt_mem.sv -----
`default_nettype none

module krt_mem #(
  parameter int ENTRIES = krt_pkg::DEF_ENTRIES,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic           clk_i,
  input  logic           rd_en_i,
  input  logic [AW-1:0]  rd_addr_i,
  output krt_pkg::rec_t  rd_data_o,
  input  logic           wr_en_i,
  input  logic [AW-1:0]  wr_addr_i,
  input  krt_pkg::rec_t  wr_data_i
);

  krt_pkg::rec_t mem_q [ENTRIES];
  krt_pkg::rec_t rd_data_q;

  // one write and one registered read per cycle, read returns old data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- design/krt_ctrl.sv -----
`default_nettype none

`include "keyed_record_table_defines.svh"

module krt_ctrl #(
  parameter int ENTRIES = krt_pkg::DEF_ENTRIES,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [krt_pkg::REQ_W-1:0]        req_type_i,
  input  logic signed [krt_pkg::KEY_W-1:0] key_i,
  input  logic [krt_pkg::PAY_W-1:0]        payload_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [krt_pkg::STAT_W-1:0]       status_o,
  output logic signed [krt_pkg::KEY_W-1:0] found_key_o,
  output logic [krt_pkg::PAY_W-1:0]        found_payload_o,
  output logic [krt_pkg::COUNT_W-1:0]      entry_count_o,
  output logic                             last_o,
  output logic                             rd_en_o,
  output logic [AW-1:0]                    rd_addr_o,
  input  krt_pkg::rec_t                    rd_data_i,
  output logic                             wr_en_o,
  output logic [AW-1:0]                    wr_addr_o,
  output krt_pkg::rec_t                    wr_data_o
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  krt_pkg::state_e state_q, state_d;
  krt_pkg::req_e   req_q, req_d;
  logic [krt_pkg::KEY_W-1:0] key_q, key_d;
  logic [krt_pkg::PAY_W-1:0] pay_q, pay_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [CW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [CW-1:0]   dst_idx;
  krt_pkg::status_e res_status_q, res_status_d;
  logic [krt_pkg::KEY_W-1:0] res_key_q, res_key_d;
  logic [krt_pkg::PAY_W-1:0] res_pay_q, res_pay_d;

  logic                      out_vld_q, out_vld_d;
  krt_pkg::status_e          out_status_q, out_status_d;
  logic [krt_pkg::KEY_W-1:0] out_key_q, out_key_d;
  logic [krt_pkg::PAY_W-1:0] out_pay_q, out_pay_d;
  logic [krt_pkg::COUNT_W-1:0] out_count_q, out_count_d;
  logic                      out_last_q, out_last_d;
  logic                      out_load;
  logic                      slot_free;
  logic                      issue;

  assign slot_free = !out_vld_q || !out_stall_i;
  assign issue     = idx_q < count_q;
  assign dst_idx   = cmp_idx_q - ONE;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    key_d        = key_q;
    pay_d        = pay_q;
    count_d      = count_q;
    idx_d        = idx_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_pay_d    = res_pay_q;
    rd_en_o      = 1'b0;
    rd_addr_o    = idx_q[AW-1:0];
    wr_en_o      = 1'b0;
    wr_addr_o    = count_q[AW-1:0];
    wr_data_o    = '{key: key_i, payload: payload_i};
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_pay_d    = out_pay_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;

    case (state_q)
      krt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d     = krt_pkg::req_e'(req_type_i);
          key_d     = key_i;
          pay_d     = payload_i;
          res_key_d = '0;
          res_pay_d = '0;
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          case (krt_pkg::req_e'(req_type_i))
            krt_pkg::REQ_ADD: begin
              if (count_q >= FULL) begin
                res_status_d = krt_pkg::STAT_FULL;
              end else begin
                wr_en_o      = 1'b1;
                count_d      = count_q + ONE;
                res_status_d = krt_pkg::STAT_OK;
              end
              state_d = krt_pkg::S_EMIT;
            end
            krt_pkg::REQ_SEARCH, krt_pkg::REQ_UPDATE, krt_pkg::REQ_DELETE: begin
              if (count_q == '0) begin
                res_status_d = krt_pkg::STAT_NOT_FOUND;
                state_d      = krt_pkg::S_EMIT;
              end else begin
                state_d = krt_pkg::S_SCAN;
              end
            end
            krt_pkg::REQ_DUMP: begin
              if (count_q == '0) begin
                res_status_d = krt_pkg::STAT_EMPTY;
                state_d      = krt_pkg::S_EMIT;
              end else begin
                state_d = krt_pkg::S_DUMP_RD;
              end
            end
            default: begin
              state_d = krt_pkg::S_IDLE;
            end
          endcase
        end
      end

      // read one record per cycle, compare the one read last cycle
      krt_pkg::S_SCAN: begin
        rd_en_o   = issue;
        cmp_vld_d = issue;
        cmp_idx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + ONE;
        end
        if (cmp_vld_q && (rd_data_i.key == key_q)) begin
          res_status_d = krt_pkg::STAT_OK;
          case (req_q)
            krt_pkg::REQ_SEARCH: begin
              res_key_d = rd_data_i.key;
              res_pay_d = rd_data_i.payload;
              state_d   = krt_pkg::S_EMIT;
            end
            krt_pkg::REQ_UPDATE: begin
              wr_en_o   = 1'b1;
              wr_addr_o = cmp_idx_q[AW-1:0];
              wr_data_o = '{key: key_q, payload: pay_q};
              state_d   = krt_pkg::S_EMIT;
            end
            krt_pkg::REQ_DELETE: begin
              idx_d     = cmp_idx_q + ONE;
              cmp_vld_d = 1'b0;
              state_d   = krt_pkg::S_SHIFT;
            end
            default: begin
              state_d = krt_pkg::S_IDLE;
            end
          endcase
        end else if (cmp_vld_q && ((cmp_idx_q + ONE) == count_q)) begin
          res_status_d = krt_pkg::STAT_NOT_FOUND;
          state_d      = krt_pkg::S_EMIT;
        end
      end

      // move each later record down one slot, read ahead of write
      krt_pkg::S_SHIFT: begin
        rd_en_o   = issue;
        cmp_vld_d = issue;
        cmp_idx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + ONE;
        end
        if (cmp_vld_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = dst_idx[AW-1:0];
          wr_data_o = rd_data_i;
        end
        if (!issue && !cmp_vld_q) begin
          count_d      = count_q - ONE;
          res_status_d = krt_pkg::STAT_OK;
          state_d      = krt_pkg::S_EMIT;
        end
      end

      krt_pkg::S_DUMP_RD: begin
        rd_en_o = 1'b1;
        state_d = krt_pkg::S_DUMP_OUT;
      end

      krt_pkg::S_DUMP_OUT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_status_d = krt_pkg::STAT_OK;
          out_key_d    = rd_data_i.key;
          out_pay_d    = rd_data_i.payload;
          out_count_d  = krt_pkg::COUNT_W'(count_q);
          out_last_d   = (idx_q + ONE) == count_q;
          if ((idx_q + ONE) == count_q) begin
            state_d = krt_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + ONE;
            state_d = krt_pkg::S_DUMP_RD;
          end
        end
      end

      krt_pkg::S_EMIT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_status_d = res_status_q;
          out_key_d    = res_key_q;
          out_pay_d    = res_pay_q;
          out_count_d  = krt_pkg::COUNT_W'(count_q);
          out_last_d   = 1'b1;
          state_d      = krt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = krt_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= krt_pkg::S_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    pay_q        <= pay_d;
    idx_q        <= idx_d;
    cmp_idx_q    <= cmp_idx_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_pay_q    <= res_pay_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_pay_q    <= out_pay_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign in_stall_o      = state_q != krt_pkg::S_IDLE;
  assign out_valid_o     = out_vld_q;
  assign status_o        = out_status_q;
  assign found_key_o     = $signed(out_key_q);
  assign found_payload_o = out_pay_q;
  assign entry_count_o   = out_count_q;
  assign last_o          = out_last_q;

  `KRT_ASSERT(a_count_bound, count_q <= FULL)
  `KRT_ASSERT(a_wr_in_range, !wr_en_o || (wr_addr_o <= count_q[AW-1:0]) || (count_q == FULL))
  `KRT_ASSERT(a_load_slot, !out_load || !out_vld_q || !out_stall_i)
  `KRT_ASSERT(a_partial_dump, !out_vld_q || out_last_q || (req_q == krt_pkg::REQ_DUMP))
  `KRT_ASSERT_NEXT(a_add_grows, in_valid_i && !in_stall_o && (req_type_i == krt_pkg::REQ_ADD) && (count_q < FULL), count_q == ($past(count_q) + ONE))

endmodule

`default_nettype wire
